// File: design/tps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tps_pkg: shared constants and types for the triangle plane slice unit
// Field widths, datapath widths, register indexes and the pipeline carry item.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int COORD_W    = 32;
    localparam int NORM_W     = 18;
    localparam int TOL_W      = 21;
    localparam int OFF_SHIFT  = 16;
    localparam int PROD_W     = NORM_W + COORD_W;
    localparam int D_W        = PROD_W + 3;
    localparam int MAG_W      = 51;
    localparam int FRAC_W     = 32;
    localparam int Q_W        = FRAC_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = FRAC_W / DIV_BITS;
    localparam int T_LO_W     = 16;
    localparam int LO_PROD_W  = DIFF_W + T_LO_W;
    localparam int HI_PROD_W  = DIFF_W + Q_W - T_LO_W;
    localparam int LERP_W     = DIFF_W + Q_W;
    localparam int NEAR_W     = 21;
    localparam int SQ_W       = 2 * NEAR_W;
    localparam int SUMSQ_W    = SQ_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    // input reg, dot product, classify, divider, 3 lerp, 3 distance/select
    localparam int PIPE_DEPTH = DIV_STAGES + 9;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

    localparam logic [NORM_W-1:0]  RST_NORMAL_X  = 18'd0;
    localparam logic [NORM_W-1:0]  RST_NORMAL_Y  = 18'd0;
    localparam logic [NORM_W-1:0]  RST_NORMAL_Z  = 18'd65536;
    localparam logic [COORD_W-1:0] RST_OFFSET    = 32'd0;
    localparam logic [TOL_W-1:0]   RST_TOLERANCE = 21'd66;

    // edge e runs from vertex e to vertex EDGE_B[e]
    localparam int EDGE_B [3] = '{1, 2, 0};
    // point pairs for the merge test
    localparam int PAIR_A [3] = '{0, 0, 1};
    localparam int PAIR_B [3] = '{1, 2, 2};

    typedef logic [2:0][2:0][COORD_W-1:0] tri_t;

    typedef struct packed {
        tri_t                           vtx;
        logic [2:0][2:0][DIFF_W-1:0]    mag;
        logic [2:0][2:0]                neg;
        logic [2:0]                     on;
        logic [2:0]                     en;
        logic                           miss;
    } carry_t;

endpackage
`default_nettype wire

// File: design/tps_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tps_div: pipelined unsigned fraction divider
// Returns num/den as Q1.32, truncated, or exactly 1.0 when num >= den.
// ----------------------------------------------------------------------------
module tps_div (
    input  logic                      clk,
    input  logic [tps_pkg::MAG_W-1:0] num,
    input  logic [tps_pkg::MAG_W-1:0] den,
    output logic [tps_pkg::Q_W-1:0]   quo
);
    import tps_pkg::*;

    logic [MAG_W-1:0]  rem_reg  [DIV_STAGES];
    logic [MAG_W-1:0]  den_reg  [DIV_STAGES];
    logic [FRAC_W-1:0] q_reg    [DIV_STAGES];
    logic              big_reg  [DIV_STAGES];

    logic [MAG_W-1:0]  rem_in   [DIV_STAGES];
    logic [MAG_W-1:0]  den_in   [DIV_STAGES];
    logic [FRAC_W-1:0] q_in     [DIV_STAGES];
    logic              big_in   [DIV_STAGES];
    logic [MAG_W-1:0]  rem_next [DIV_STAGES];
    logic [FRAC_W-1:0] q_next   [DIV_STAGES];

    always_comb
    begin
        big_in[0] = (num >= den);
        rem_in[0] = (num >= den) ? '0 : num;
        den_in[0] = den;
        q_in[0]   = '0;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            big_in[s] = big_reg[s-1];
            rem_in[s] = rem_reg[s-1];
            den_in[s] = den_reg[s-1];
            q_in[s]   = q_reg[s-1];
        end
    end

    // restoring division, DIV_BITS quotient bits per stage
    always_comb
    begin
        logic [MAG_W:0] sh;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_next[s] = rem_in[s];
            q_next[s]   = q_in[s];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                sh = {rem_next[s], 1'b0};
                if (sh >= {1'b0, den_in[s]})
                begin
                    sh        = sh - {1'b0, den_in[s]};
                    q_next[s] = {q_next[s][FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    q_next[s] = {q_next[s][FRAC_W-2:0], 1'b0};
                end
                rem_next[s] = sh[MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            den_reg[s] <= den_in[s];
            q_reg[s]   <= q_next[s];
            big_reg[s] <= big_in[s];
        end
    end

    assign quo = big_reg[DIV_STAGES-1] ? {1'b1, {FRAC_W{1'b0}}}
                                       : {1'b0, q_reg[DIV_STAGES-1]};

endmodule
`default_nettype wire

// File: design/triangle_plane_slice_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_plane_slice_unit: slices one triangle against a plane per clock
// Classifies vertices, interpolates edge crossings and returns the segment.
// ----------------------------------------------------------------------------
// One triangle is taken on every clock where start is high; busy is always low.
// Each item yields exactly one result, in item order. done is high for one
// cycle, and the result is valid while done is high. The receiver cannot stall.
// The pipeline holds the 16-stage crossing divider (two quotient bits a stage)
// plus three stages before it and six after it. The user must let the pipeline
// drain before writing plane and tolerance registers, so they take effect for
// items accepted after; the block itself does not enforce this.
module triangle_plane_slice_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_write,
    input  logic [tps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [tps_pkg::COORD_W-1:0]  v0_x,
    input  logic signed [tps_pkg::COORD_W-1:0]  v0_y,
    input  logic signed [tps_pkg::COORD_W-1:0]  v0_z,
    input  logic signed [tps_pkg::COORD_W-1:0]  v1_x,
    input  logic signed [tps_pkg::COORD_W-1:0]  v1_y,
    input  logic signed [tps_pkg::COORD_W-1:0]  v1_z,
    input  logic signed [tps_pkg::COORD_W-1:0]  v2_x,
    input  logic signed [tps_pkg::COORD_W-1:0]  v2_y,
    input  logic signed [tps_pkg::COORD_W-1:0]  v2_z,
    output logic                                done,
    output logic                                hit,
    output logic signed [tps_pkg::COORD_W-1:0]  start_x,
    output logic signed [tps_pkg::COORD_W-1:0]  start_y,
    output logic signed [tps_pkg::COORD_W-1:0]  start_z,
    output logic signed [tps_pkg::COORD_W-1:0]  end_x,
    output logic signed [tps_pkg::COORD_W-1:0]  end_y,
    output logic signed [tps_pkg::COORD_W-1:0]  end_z
);
    import tps_pkg::*;

    // ---------------- configuration ----------------
    logic [NORM_W-1:0]  nx_reg, ny_reg, nz_reg;
    logic [COORD_W-1:0] off_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [SQ_W-1:0]    tol2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= RST_NORMAL_X;
            ny_reg  <= RST_NORMAL_Y;
            nz_reg  <= RST_NORMAL_Z;
            off_reg <= RST_OFFSET;
            tol_reg <= RST_TOLERANCE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NORMAL_X:  nx_reg  <= cfg_data[NORM_W-1:0];
                REG_NORMAL_Y:  ny_reg  <= cfg_data[NORM_W-1:0];
                REG_NORMAL_Z:  nz_reg  <= cfg_data[NORM_W-1:0];
                REG_OFFSET:    off_reg <= cfg_data[COORD_W-1:0];
                REG_TOLERANCE: tol_reg <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tol2_reg <= SQ_W'(tol_reg) * SQ_W'(tol_reg);
    end

    // ---------------- valid chain ----------------
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start && !busy};
    end

    // ---------------- stage P: products ----------------
    tri_t                     vin;
    logic [2:0][NORM_W-1:0]   nrm;
    logic signed [PROD_W-1:0] prod_reg [3][3];
    tri_t                     vtx_p_reg;

    assign vin[0][0] = v0_x;
    assign vin[0][1] = v0_y;
    assign vin[0][2] = v0_z;
    assign vin[1][0] = v1_x;
    assign vin[1][1] = v1_y;
    assign vin[1][2] = v1_z;
    assign vin[2][0] = v2_x;
    assign vin[2][1] = v2_y;
    assign vin[2][2] = v2_z;
    assign nrm[0] = nx_reg;
    assign nrm[1] = ny_reg;
    assign nrm[2] = nz_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                prod_reg[i][k] <= PROD_W'($signed(nrm[k])) * PROD_W'($signed(vin[i][k]));
        vtx_p_reg <= vin;
    end

    // ---------------- stage S: signed distance ----------------
    logic signed [D_W-1:0] off_sh;
    logic signed [D_W-1:0] d_next [3];
    logic signed [D_W-1:0] d_reg  [3];
    tri_t                  vtx_s_reg;

    assign off_sh = {{(D_W-COORD_W-OFF_SHIFT){off_reg[COORD_W-1]}}, off_reg,
                     {OFF_SHIFT{1'b0}}};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_next[i] = D_W'(prod_reg[i][0]) + D_W'(prod_reg[i][1])
                      + D_W'(prod_reg[i][2]) - off_sh;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            d_reg[i] <= d_next[i];
        vtx_s_reg <= vtx_p_reg;
    end

    // ---------------- stage C: classify, divider operands ----------------
    logic [D_W-1:0]     mag_d  [3];
    logic [MAG_W-1:0]   magv   [3];
    logic [2:0]         on_c, pos_c;
    logic [D_W-1:0]     tolq;
    logic [MAG_W-1:0]   num_next [3];
    logic [MAG_W-1:0]   den_next [3];
    logic [MAG_W-1:0]   num_reg  [3];
    logic [MAG_W-1:0]   den_reg  [3];
    carry_t             crr_next;
    carry_t             crr_reg [DIV_STAGES+1];

    assign tolq = D_W'({tol_reg, {OFF_SHIFT{1'b0}}});

    always_comb
    begin
        logic [DIFF_W-1:0] diff;
        int b;
        for (int i = 0; i < 3; i++)
        begin
            mag_d[i] = d_reg[i][D_W-1] ? D_W'(-d_reg[i]) : D_W'(d_reg[i]);
            magv[i]  = mag_d[i][MAG_W-1:0];
            on_c[i]  = (mag_d[i] < tolq);
            pos_c[i] = !d_reg[i][D_W-1] && (d_reg[i] != '0);
        end
        crr_next.vtx  = vtx_s_reg;
        crr_next.on   = on_c;
        crr_next.miss = (&(~on_c & pos_c)) || (&(~on_c & ~pos_c));
        for (int e = 0; e < 3; e++)
        begin
            b = EDGE_B[e];
            num_next[e] = magv[e];
            den_next[e] = magv[e] + magv[b];
            crr_next.en[e] = !(on_c[e] && on_c[b])
                           && (on_c[e] || on_c[b] || (pos_c[e] != pos_c[b]));
            for (int k = 0; k < 3; k++)
            begin
                diff = {vtx_s_reg[b][k][COORD_W-1], vtx_s_reg[b][k]}
                     - {vtx_s_reg[e][k][COORD_W-1], vtx_s_reg[e][k]};
                crr_next.neg[e][k] = diff[DIFF_W-1];
                crr_next.mag[e][k] = diff[DIFF_W-1] ? -diff : diff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 3; e++)
        begin
            num_reg[e] <= num_next[e];
            den_reg[e] <= den_next[e];
        end
        crr_reg[0] <= crr_next;
        for (int s = 1; s <= DIV_STAGES; s++)
            crr_reg[s] <= crr_reg[s-1];
    end

    // ---------------- crossing fraction ----------------
    logic [Q_W-1:0] quo [3];

    tps_div u_div0 (.clk(clk), .num(num_reg[0]), .den(den_reg[0]), .quo(quo[0]));
    tps_div u_div1 (.clk(clk), .num(num_reg[1]), .den(den_reg[1]), .quo(quo[1]));
    tps_div u_div2 (.clk(clk), .num(num_reg[2]), .den(den_reg[2]), .quo(quo[2]));

    // ---------------- M1: partial products ----------------
    logic [LO_PROD_W-1:0] pp_lo_reg [3][3];
    logic [HI_PROD_W-1:0] pp_hi_reg [3][3];
    carry_t               crr_m1_reg;

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 3; e++)
            for (int k = 0; k < 3; k++)
            begin
                pp_lo_reg[e][k] <= LO_PROD_W'(crr_reg[DIV_STAGES].mag[e][k])
                                 * LO_PROD_W'(quo[e][T_LO_W-1:0]);
                pp_hi_reg[e][k] <= HI_PROD_W'(crr_reg[DIV_STAGES].mag[e][k])
                                 * HI_PROD_W'(quo[e][Q_W-1:T_LO_W]);
            end
        crr_m1_reg <= crr_reg[DIV_STAGES];
    end

    // ---------------- M2: rounded step ----------------
    logic [LERP_W-1:0] lerp_sum [3][3];
    logic [DIFF_W-1:0] q_reg    [3][3];
    carry_t            crr_m2_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
            for (int k = 0; k < 3; k++)
                lerp_sum[e][k] = LERP_W'(pp_lo_reg[e][k])
                               + (LERP_W'(pp_hi_reg[e][k]) << T_LO_W)
                               + (LERP_W'(1) << (FRAC_W-1));
    end

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 3; e++)
            for (int k = 0; k < 3; k++)
                q_reg[e][k] <= lerp_sum[e][k][FRAC_W+DIFF_W-1:FRAC_W];
        crr_m2_reg <= crr_m1_reg;
    end

    // ---------------- M3: edge points ----------------
    tri_t       pt_next, pt_m3_reg;
    logic [2:0] en_m3_reg;
    logic       miss_m3_reg;

    always_comb
    begin
        logic [DIFF_W-1:0] ax, r;
        int b;
        for (int e = 0; e < 3; e++)
        begin
            b = EDGE_B[e];
            for (int k = 0; k < 3; k++)
            begin
                ax = {crr_m2_reg.vtx[e][k][COORD_W-1], crr_m2_reg.vtx[e][k]};
                r  = crr_m2_reg.neg[e][k] ? ax - q_reg[e][k] : ax + q_reg[e][k];
                if (crr_m2_reg.on[e])
                    pt_next[e][k] = crr_m2_reg.vtx[e][k];
                else if (crr_m2_reg.on[b])
                    pt_next[e][k] = crr_m2_reg.vtx[b][k];
                else
                    pt_next[e][k] = r[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pt_m3_reg   <= pt_next;
        en_m3_reg   <= crr_m2_reg.en;
        miss_m3_reg <= crr_m2_reg.miss;
    end

    // ---------------- D1: per-axis squares ----------------
    logic [SQ_W-1:0] sq_reg  [3][3];
    logic [2:0]      far_reg;
    tri_t            pt_d1_reg;
    logic [2:0]      en_d1_reg;
    logic            miss_d1_reg;
    logic [2:0]      far_next;
    logic [DIFF_W-1:0] am [3][3];

    always_comb
    begin
        logic [DIFF_W-1:0] diff;
        for (int p = 0; p < 3; p++)
        begin
            far_next[p] = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                diff = {pt_m3_reg[PAIR_A[p]][k][COORD_W-1], pt_m3_reg[PAIR_A[p]][k]}
                     - {pt_m3_reg[PAIR_B[p]][k][COORD_W-1], pt_m3_reg[PAIR_B[p]][k]};
                am[p][k] = diff[DIFF_W-1] ? -diff : diff;
                if (|am[p][k][DIFF_W-1:NEAR_W])
                    far_next[p] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 3; p++)
            for (int k = 0; k < 3; k++)
                sq_reg[p][k] <= SQ_W'(am[p][k][NEAR_W-1:0]) * SQ_W'(am[p][k][NEAR_W-1:0]);
        far_reg     <= far_next;
        pt_d1_reg   <= pt_m3_reg;
        en_d1_reg   <= en_m3_reg;
        miss_d1_reg <= miss_m3_reg;
    end

    // ---------------- D2: compare with tolerance ----------------
    logic [SUMSQ_W-1:0] sumsq [3];
    logic [2:0]         lt_next, gt_next, lt_reg, gt_reg;
    tri_t               pt_d2_reg;
    logic [2:0]         en_d2_reg;
    logic               miss_d2_reg;

    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            sumsq[p]   = SUMSQ_W'(sq_reg[p][0]) + SUMSQ_W'(sq_reg[p][1])
                       + SUMSQ_W'(sq_reg[p][2]);
            lt_next[p] = !far_reg[p] && (sumsq[p] < SUMSQ_W'(tol2_reg));
            gt_next[p] = far_reg[p] || (sumsq[p] > SUMSQ_W'(tol2_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        lt_reg      <= lt_next;
        gt_reg      <= gt_next;
        pt_d2_reg   <= pt_d1_reg;
        en_d2_reg   <= en_d1_reg;
        miss_d2_reg <= miss_d1_reg;
    end

    // ---------------- D3: merge and result ----------------
    logic [2:0]                  keep;
    logic                        hit_next, hit_reg;
    logic [2:0][COORD_W-1:0]     sp_next, ep_next, sp_reg, ep_reg;

    always_comb
    begin
        logic pair_gt;
        // pairs: 0 = (0,1), 1 = (0,2), 2 = (1,2)
        keep[0] = en_d2_reg[0];
        keep[1] = en_d2_reg[1] && !(keep[0] && lt_reg[0]);
        keep[2] = en_d2_reg[2] && !(keep[0] && lt_reg[1]) && !(keep[1] && lt_reg[2]);
        sp_next = pt_d2_reg[0];
        ep_next = pt_d2_reg[1];
        pair_gt = gt_reg[0];
        if (!keep[0])
        begin
            sp_next = pt_d2_reg[1];
            ep_next = pt_d2_reg[2];
            pair_gt = gt_reg[2];
        end
        else if (!keep[1])
        begin
            ep_next = pt_d2_reg[2];
            pair_gt = gt_reg[1];
        end
        hit_next = !miss_d2_reg && ($countones(keep) == 2) && pair_gt;
        if (!hit_next)
        begin
            sp_next = '0;
            ep_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        sp_reg  <= sp_next;
        ep_reg  <= ep_next;
    end

    assign done    = vld_reg[PIPE_DEPTH-1];
    assign hit     = hit_reg;
    assign start_x = sp_reg[0];
    assign start_y = sp_reg[1];
    assign start_z = sp_reg[2];
    assign end_x   = ep_reg[0];
    assign end_y   = ep_reg[1];
    assign end_z   = ep_reg[2];

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> start_x == 0 && start_y == 0 && start_z == 0
                      && end_x == 0 && end_y == 0 && end_z == 0)
        else $error("miss result with nonzero coordinates");

    a_hit_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> start_x != end_x || start_y != end_y || start_z != end_z)
        else $error("hit with coincident end points");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without matching item");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the triangle plane slice unit
// Drives triangles into the unit and checks every slice result against a
// local model of the classify, crossing and merge arithmetic (typed rows use a
// given result). The plane and tolerance are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import tps_pkg::*;

    localparam int DRAIN_CYCLES = PIPE_DEPTH + 10;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        logic   hit;
        coord_t p0 [3];
        coord_t p1 [3];
    } slice_t;

    typedef struct {
        coord_t vtx [9];
        bit     typed;
        slice_t want;
    } tri_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    coord_t                vin [9];
    logic                  done;
    logic                  hit;
    coord_t                start_x, start_y, start_z, end_x, end_y, end_z;

    // local copy of the plane registers
    logic [NORM_W-1:0]  nrm_x, nrm_y, nrm_z;
    logic [COORD_W-1:0] offset;
    logic [TOL_W-1:0]   tol;

    slice_t  slice_q [$];
    int      errors;
    int      pending;
    tri_row_t rows [$];

    triangle_plane_slice_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]),
        .v1_x(vin[3]), .v1_y(vin[4]), .v1_z(vin[5]),
        .v2_x(vin[6]), .v2_y(vin[7]), .v2_z(vin[8]),
        .done(done), .hit(hit),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // squared distance, 2^62 when some axis is 2^21 or more apart
    function automatic longint unsigned sep_sq(longint a [3], longint b [3]);
        longint unsigned s;
        longint unsigned m;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            m = abs64(a[k] - b[k]);
            if (m >= (64'd1 << 21))
                return 64'd1 << 62;
            s += m * m;
        end
        return s;
    endfunction

    function automatic slice_t slice_triangle(coord_t vt [9]);
        slice_t r;
        longint v [3][3];
        longint d [3];
        longint pts [3][3];
        longint uq [3][3];
        int cls [3];
        int cnt, ucnt, a, b;
        longint nx, ny, nz, off, tolq;
        longint unsigned tol2, n, den, t, rem, q;
        longint diff;
        bit dup;
        nx = longint'(signed'(nrm_x));
        ny = longint'(signed'(nrm_y));
        nz = longint'(signed'(nrm_z));
        off = longint'(signed'(offset)) * 65536;
        tolq = longint'(tol) * 65536;
        tol2 = longint'(tol) * longint'(tol);
        cnt = 0;
        ucnt = 0;
        r.hit = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            r.p0[k] = '0;
            r.p1[k] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                v[i][k] = longint'(vt[i*3+k]);
            d[i] = nx * v[i][0] + ny * v[i][1] + nz * v[i][2] - off;
            if (longint'(abs64(d[i])) < tolq)
                cls[i] = 0;
            else
                cls[i] = d[i] > 0 ? 1 : -1;
        end
        if ((cls[0] > 0 && cls[1] > 0 && cls[2] > 0) ||
            (cls[0] < 0 && cls[1] < 0 && cls[2] < 0))
            return r;
        for (int i = 0; i < 3; i++)
        begin
            a = i;
            b = (i + 1) % 3;
            if (cls[a] == 0 && cls[b] == 0)
                continue;
            if (cls[a] == 0)
                pts[cnt++] = v[a];
            else if (cls[b] == 0)
                pts[cnt++] = v[b];
            else if (cls[a] != cls[b])
            begin
                n = abs64(d[a]);
                den = n + abs64(d[b]);
                if (n >= den)
                    t = 64'd1 << 32;
                else
                begin
                    rem = n;
                    t = 0;
                    for (int k = 0; k < 32; k++)
                    begin
                        rem = rem << 1;
                        t = t << 1;
                        if (rem >= den)
                        begin
                            rem -= den;
                            t |= 1;
                        end
                    end
                end
                for (int k = 0; k < 3; k++)
                begin
                    diff = v[b][k] - v[a][k];
                    q = (abs64(diff) * t + (64'd1 << 31)) >> 32;
                    pts[cnt][k] = diff < 0 ? v[a][k] - longint'(q) : v[a][k] + longint'(q);
                end
                cnt++;
            end
        end
        for (int i = 0; i < cnt; i++)
        begin
            dup = 1'b0;
            for (int j = 0; j < ucnt; j++)
                if (sep_sq(pts[i], uq[j]) < tol2)
                    dup = 1'b1;
            if (!dup)
                uq[ucnt++] = pts[i];
        end
        if (ucnt == 2 && sep_sq(uq[0], uq[1]) > tol2)
        begin
            r.hit = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                r.p0[k] = coord_t'(uq[0][k]);
                r.p1[k] = coord_t'(uq[1][k]);
            end
        end
        return r;
    endfunction

    // one register write; the caller drops cfg_write after the last one
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_NORMAL_X:  nrm_x = val[NORM_W-1:0];
            REG_NORMAL_Y:  nrm_y = val[NORM_W-1:0];
            REG_NORMAL_Z:  nrm_z = val[NORM_W-1:0];
            REG_OFFSET:    offset = val;
            REG_TOLERANCE: tol = val[TOL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_plane(int nx, int ny, int nz, int off, int tl);
        set_reg(REG_NORMAL_X, 32'(nx));
        set_reg(REG_NORMAL_Y, 32'(ny));
        set_reg(REG_NORMAL_Z, 32'(nz));
        set_reg(REG_OFFSET, 32'(off));
        set_reg(REG_TOLERANCE, 32'(tl));
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        while (slice_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one item; start stays high across back-to-back items
    task automatic send_tri(coord_t vt [9], bit gaps, bit typed, slice_t want);
        int g;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start <= 1'b1;
        for (int k = 0; k < 9; k++)
            vin[k] <= vt[k];
        slice_q.push_back(typed ? want : slice_triangle(vt));
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            default: return coord_t'(int'($urandom_range(0, 16'hFFFF)) - 32'sh8000);
        endcase
    endfunction

    task automatic random_phase(int count, bit gaps);
        coord_t vt [9];
        slice_t none;
        int mode;
        none.hit = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 5);
            for (int k = 0; k < 9; k++)
                vt[k] = rnd_coord(mode % 3);
            // pin a vertex or two near the plane z = offset/nz style cases
            if (mode >= 3)
                vt[$urandom_range(0, 2)*3+2] = coord_t'(offset) + coord_t'($urandom_range(0, 4)) - 2;
            if (mode == 5)
            begin
                vt[0] = vt[3];
                vt[1] = vt[4];
                vt[2] = vt[5];
            end
            send_tri(vt, gaps, 1'b0, none);
        end
        start <= 1'b0;
        @(posedge clk);
    endtask

    // result check
    always @(posedge clk)
    begin
        slice_t w;
        if (rst_n && done)
        begin
            if (slice_q.size() == 0)
            begin
                $display("%0t: unexpected result, none pending", $time);
                errors++;
            end
            else
            begin
                w = slice_q.pop_front();
                if (hit !== w.hit || start_x !== w.p0[0] || start_y !== w.p0[1] ||
                    start_z !== w.p0[2] || end_x !== w.p1[0] || end_y !== w.p1[1] ||
                    end_z !== w.p1[2])
                begin
                    $display("%0t: mismatch expected %b %0d %0d %0d %0d %0d %0d",
                             $time, w.hit, w.p0[0], w.p0[1], w.p0[2],
                             w.p1[0], w.p1[1], w.p1[2]);
                    $display("%0t:          actual   %b %0d %0d %0d %0d %0d %0d",
                             $time, hit, start_x, start_y, start_z, end_x, end_y, end_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        tri_row_t row;
        slice_t none;
        localparam int ONE = 65536;
        errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int k = 0; k < 9; k++)
            vin[k] = '0;
        nrm_x = RST_NORMAL_X;
        nrm_y = RST_NORMAL_Y;
        nrm_z = RST_NORMAL_Z;
        offset = RST_OFFSET;
        tol = RST_TOLERANCE;
        none.hit = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            none.p0[k] = '0;
            none.p1[k] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset plane z = 0
        row.typed = 1'b1;
        row.want = none;
        // all above
        row.vtx = '{0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE};
        rows.push_back(row);
        // all below
        row.vtx = '{0, 0, -ONE, ONE, 0, -ONE, 0, ONE, -ONE};
        rows.push_back(row);
        // zero distance counts as on-plane here: all three on, no edge gives a point
        row.vtx = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0};
        rows.push_back(row);
        // coordinate extremes, all below
        row.vtx = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh7FFFFFFF, 32'sh80000000, 0, 0, 32'sh80000000};
        rows.push_back(row);
        // edge on plane, apex above: hit with the two on-plane vertices
        row.vtx = '{0, 0, 0, ONE, 0, 0, 0, ONE, ONE};
        row.want.hit = 1'b1;
        row.want.p0 = '{ONE, 0, 0};
        row.want.p1 = '{0, 0, 0};
        rows.push_back(row);
        row.typed = 1'b0;
        // proper crossing
        row.vtx = '{0, 0, -ONE, ONE, 0, ONE, 0, ONE, ONE};
        rows.push_back(row);
        // single vertex touching
        row.vtx = '{0, 0, 0, ONE, 0, ONE, 0, ONE, ONE};
        rows.push_back(row);
        // vertex on, opposite edge crossing
        row.vtx = '{0, 0, 0, ONE, 0, -ONE, 0, ONE, ONE};
        rows.push_back(row);
        // tiny triangle, points merge
        row.vtx = '{0, 0, -1, 1, 0, 1, 0, 1, 1};
        rows.push_back(row);
        // huge span crossing
        row.vtx = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 5};
        rows.push_back(row);
        // just inside and just outside the tolerance
        row.vtx = '{0, 0, 65, ONE, 0, -65, 0, ONE, 66};
        rows.push_back(row);
        row.vtx = '{0, 0, 67, ONE, 0, -67, 0, ONE, ONE};
        rows.push_back(row);
        foreach (rows[i])
            send_tri(rows[i].vtx, 1'b0, rows[i].typed, rows[i].want);
        start <= 1'b0;
        @(posedge clk);
        random_phase(250, 1'b1);
        drain();

        // tilted plane, zero tolerance
        set_plane(37837, 37837, 37837, 1000, 0);
        random_phase(250, 1'b1);
        drain();

        // unit-magnitude normal components, maximum offset, wide tolerance
        set_plane(-65536, 65536, -65536, 32'sh7FFFFFFF, 1048576);
        random_phase(200, 1'b1);
        drain();

        // extremes of the normal range, all-ones tolerance, minimum offset
        set_plane(131071, -131072, 1, 32'sh80000000, 21'h1FFFFF);
        random_phase(150, 1'b1);
        drain();

        set_plane(0, 65536, 0, -ONE, 5);
        random_phase(200, 1'b1);
        drain();

        // back to the default plane, continuous streaming at the end
        set_plane(0, 0, 65536, 0, 66);
        random_phase(290, 1'b0);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
design/tps_pkg.sv
design/tps_div.sv
design/triangle_plane_slice_unit.sv
tb/sv/tb_top.sv
